### src/vlt_pkg.sv
// Shared types, constants and helpers for the voxel line traversal core.
// Holds the job record passed from the request front end to the walker.
// No dependencies.
package vlt_pkg;

    localparam int COORD_W    = 4;
    localparam int NUM_AXES   = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ODD_W      = COORD_W + 1;
    localparam int PROD_W     = ODD_W + COORD_W;

    typedef logic [COORD_W-1:0] coord_t;

    // One line request after classification: start voxel, per-axis length and direction
    typedef struct packed {
        coord_t [NUM_AXES-1:0] pos;
        coord_t [NUM_AXES-1:0] len;
        logic   [NUM_AXES-1:0] up;
    } job_t;

    // True when axis a crosses its next boundary strictly before axis b
    function automatic logic axis_earlier(
        input coord_t len_a,
        input coord_t taken_a,
        input coord_t len_b,
        input coord_t taken_b
    );
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        logic              res;
        lhs = PROD_W'({taken_a, 1'b1}) * PROD_W'(len_b);
        rhs = PROD_W'({taken_b, 1'b1}) * PROD_W'(len_a);
        if (taken_a == len_a)
        begin
            res = 1'b0;
        end
        else if (taken_b == len_b)
        begin
            res = 1'b1;
        end
        else
        begin
            res = lhs < rhs;
        end
        return res;
    endfunction

endpackage

### src/voxel_line_traversal_core.sv
// Top level of the voxel line traversal core.
// Joins the request front end (vlt_front) and the walker (vlt_walker); uses vlt_pkg.

// Takes a line request (start and end voxel, 4-bit coordinates each) and streams
// every voxel of the 3D DDA walk from start to end, one word per voxel, with tlast
// on the end voxel. A request yields |dx|+|dy|+|dz|+1 words (at most 46). The walker
// emits one voxel per cycle while the output is ready and loads each request in its
// idle state before walking it. A two-entry queue after the input lets up to two
// further requests be taken while a walk is in progress. Boundary crossings are
// compared exactly in integers; ties step z before y before x. Coordinates wrap at
// 4 bits.
module voxel_line_traversal_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_x[3:0], start_y[7:4], start_z[11:8], end_x[15:12], end_y[19:16], end_z[23:20]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // voxel_x[3:0], voxel_y[7:4], voxel_z[11:8], zero fill[15:12]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);
    import vlt_pkg::*;

    logic job_valid;
    logic job_ready;
    job_t job;

    // Accept and classify requests
    vlt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Walk the line and stream voxels
    vlt_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### src/vlt_front.sv
// Request front end: unpacks a line request, derives axis lengths and directions,
// and holds classified jobs in a short queue for the walker.
// Depends on vlt_pkg.
module vlt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vlt_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          job_valid,
    input  logic                          job_ready,
    output vlt_pkg::job_t                 job
);
    import vlt_pkg::*;

    job_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    job_t              new_job;
    logic              push;
    logic              pop;

    // Classify: start position, absolute length and step direction per axis
    always_comb
    begin
        coord_t start_c;
        coord_t end_c;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            start_c        = s_tdata[i*COORD_W +: COORD_W];
            end_c          = s_tdata[(i+NUM_AXES)*COORD_W +: COORD_W];
            new_job.pos[i] = start_c;
            new_job.up[i]  = end_c > start_c;
            new_job.len[i] = (end_c > start_c) ? (end_c - start_c) : (start_c - end_c);
        end
    end

    assign s_tready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign push      = s_tvalid && s_tready;
    assign job_valid = count_reg != '0;
    assign pop       = job_valid && job_ready;
    assign job       = queue_mem[rd_ptr_reg];

    // Advance queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store accepted jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_job;
        end
    end

endmodule

### src/vlt_walker.sv
// Walker back end: steps one voxel per cycle, while the output is free, along the DDA path of the current job
// and drives the registered output word.
// Depends on vlt_pkg.
module vlt_walker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  vlt_pkg::job_t                  job,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vlt_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import vlt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    coord_t [NUM_AXES-1:0]        pos_reg;
    coord_t [NUM_AXES-1:0]        pos_next;
    coord_t [NUM_AXES-1:0]        len_reg;
    coord_t [NUM_AXES-1:0]        len_next;
    coord_t [NUM_AXES-1:0]        taken_reg;
    coord_t [NUM_AXES-1:0]        taken_next;
    logic   [NUM_AXES-1:0]        up_reg;
    logic   [NUM_AXES-1:0]        up_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    coord_t [NUM_AXES-1:0]        out_pos_reg;
    coord_t [NUM_AXES-1:0]        out_pos_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic                         done;
    logic                         out_free;
    logic                         e_xy;
    logic                         e_xz;
    logic                         e_yz;
    logic   [NUM_AXES-1:0]        sel;

    assign done      = (taken_reg == len_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign job_ready = (state_reg == ST_IDLE);

    // Pick the axis with the earliest next crossing; ties favor z, then y
    assign e_xy = axis_earlier(len_reg[0], taken_reg[0], len_reg[1], taken_reg[1]);
    assign e_xz = axis_earlier(len_reg[0], taken_reg[0], len_reg[2], taken_reg[2]);
    assign e_yz = axis_earlier(len_reg[1], taken_reg[1], len_reg[2], taken_reg[2]);

    always_comb
    begin
        sel = '0;
        if (e_xy)
        begin
            sel[0] = e_xz;
            sel[2] = !e_xz;
        end
        else
        begin
            sel[1] = e_yz;
            sel[2] = !e_yz;
        end
    end

    // Load a job when idle, emit and step while walking
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        taken_next     = taken_reg;
        up_next        = up_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pos_next   = job.pos;
                    len_next   = job.len;
                    up_next    = job.up;
                    taken_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_last_next  = done;
                    if (done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            if (sel[i])
                            begin
                                pos_next[i]   = up_reg[i] ? pos_reg[i] + 1'b1
                                                          : pos_reg[i] - 1'b1;
                                taken_next[i] = taken_reg[i] + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, walk registers and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            taken_reg     <= '0;
            up_reg        <= '0;
            out_pos_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            taken_reg     <= taken_next;
            up_reg        <= up_next;
            out_pos_reg   <= out_pos_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_pos_reg);
    assign m_tlast  = out_last_reg;

endmodule
